FILE: sv/isu_pkg.sv
// Package for the insertion sorter: data width and the link types shared by
// the sorting cells and the top level. No dependencies.
package isu_pkg;

  localparam int unsigned DataWidth = 32;

  typedef logic signed [DataWidth-1:0] data_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic  insert;
    logic  shift;
    data_t value;
  } cell_ctrl_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic  valid;
    logic  gt;
    data_t value;
  } cell_link_t;

endpackage : isu_pkg

FILE: sv/isu_stream_if.sv
// Valid/ready stream interfaces for the insertion sorter's input and output.
// Depends on isu_pkg for the data type.
interface isu_in_if
  import isu_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface : isu_in_if

interface isu_out_if
  import isu_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_result;
  logic  overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflowed, output ready);
endinterface : isu_out_if

FILE: sv/insertion_sorter_unit.sv
// Insertion sorter: loads a list of signed 32-bit values one per cycle into a
// chain of DEPTH cells that keep it sorted, then streams it out in ascending
// order. Depends on isu_pkg, isu_stream_if and isu_cell.
//
// Loading takes one value per cycle: every cell compares itself with the new
// value at once and the greater entries move up one cell. When the value
// marked last has been taken, the input stalls and the list leaves the bottom
// cell, one result per cycle while the output is ready; the shift through
// the cell chain sets the emission rate. Values that arrive while all DEPTH
// cells are full are dropped, and every result of that list then carries
// overflowed. Equal values leave in their order of arrival.
module insertion_sorter_unit
  import isu_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  isu_in_if.sink    in_i,
  isu_out_if.source out_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic             state_q, state_d;
  logic             drop_q, drop_d;
  logic             in_xfer, out_xfer, full;
  logic [DEPTH-1:0] valid;
  cell_ctrl_t       ctrl;
  cell_link_t       link [DEPTH];

  assign full     = valid[DEPTH-1];
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  assign in_i.ready = (state_q == StLoad);

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = out_xfer;
  assign ctrl.value  = in_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t lower, upper;

    if (i == 0) begin : g_bottom
      assign lower = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_lower
      assign lower = link[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_upper
      assign upper = link[i+1];
    end

    isu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .link_o  (link[i])
    );

    assign valid[i] = link[i].valid;
  end

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    case (state_q)
      StLoad: begin
        if (in_xfer) begin
          if (full) begin
            drop_d = 1'b1;
          end
          if (in_i.last_item) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        // The transfer of the final result empties the chain.
        if (out_xfer && !valid[1]) begin
          state_d = StLoad;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  assign out_o.valid        = (state_q == StEmit) && valid[0];
  assign out_o.sorted_value = link[0].value;
  assign out_o.last_result  = !valid[1];
  assign out_o.overflowed   = drop_q;

  // A list is never empty while it is being emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> valid[0])
    else $error("emission with an empty chain");

  // When the top cell is occupied, every cell below it is occupied too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (&valid))
    else $error("hole in the cell chain");

  // Taking the last value starts emission with at least one entry held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last_item) |=> (state_q == StEmit) && valid[0])
    else $error("last value did not start emission");

  // After the final result is transferred the chain is empty and loading resumes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_o.last_result) |=> !valid[0] && (state_q == StLoad) && !drop_q)
    else $error("chain not cleared after final result");

endmodule : insertion_sorter_unit

FILE: sv/isu_cell.sv
// One cell of the insertion chain: holds a single entry and its valid bit.
// Depends on isu_pkg for the control and link types.
module isu_cell
  import isu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_link_t lower_i,
  input  cell_link_t upper_i,
  output cell_link_t link_o
);

  logic  valid_q, valid_d;
  data_t value_q, value_d;
  logic  gt;

  assign gt = valid_q && (value_q > ctrl_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.insert) begin
      // Entries greater than the new value move up one place; the new value
      // lands in the lowest cell that either held a greater entry or was the
      // first free one.
      valid_d = valid_q | lower_i.valid;
      if (lower_i.gt) begin
        value_d = lower_i.value;
      end else if (gt || (!valid_q && lower_i.valid)) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      valid_d = upper_i.valid;
      value_d = upper_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.gt    = gt;
  assign link_o.value = value_q;

endmodule : isu_cell

FILE: tb/sv/tb_insertion_sorter_unit.sv
// Self-checking testbench for insertion_sorter_unit: drives lists of signed values,
// predicts the sorted output, and checks every result transfer field by field.
// Depends on isu_pkg, isu_stream_if and the RTL of insertion_sorter_unit.
module tb_insertion_sorter_unit;
  import isu_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned MaxIdle = 3000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned TargetValues = 410;
  localparam data_t MinValue = {1'b1, {(DataWidth-1){1'b0}}};
  localparam data_t MaxValue = {1'b0, {(DataWidth-1){1'b1}}};

  typedef struct packed {
    data_t sorted_value;
    logic  last_result;
    logic  overflowed;
  } sorted_result_t;

  // Keeps its own sorted copy of the list being loaded and the results still due.
  class sorted_list_checker;
    data_t          kept[Depth];
    int unsigned    held;
    bit             dropped;
    sorted_result_t due_results[$];
    int unsigned    errors, lists, values, results, overflow_lists, longest;

    function void note_value(data_t v, logic is_last);
      int unsigned pos;
      sorted_result_t r;
      values++;
      if (held < Depth) begin
        pos = held;
        // Strictly greater entries move up, so equal values keep arrival order.
        while (pos > 0 && kept[pos-1] > v) begin
          kept[pos] = kept[pos-1];
          pos--;
        end
        kept[pos] = v;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        for (int unsigned k = 0; k < held; k++) begin
          r.sorted_value = kept[k];
          r.last_result  = (k + 1 == held);
          r.overflowed   = dropped;
          due_results.push_back(r);
        end
        lists++;
        if (dropped) overflow_lists++;
        if (held > longest) longest = held;
        held    = 0;
        dropped = 1'b0;
      end
    endfunction

    function void check_result(data_t v, logic is_last, logic ovf);
      sorted_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: value %0d last %0b overflowed %0b",
                 $time, v, is_last, ovf);
        return;
      end
      want = due_results.pop_front();
      results++;
      if (v !== want.sorted_value) begin
        errors++;
        $display("%0t: sorted_value expected %0d actual %0d", $time, want.sorted_value, v);
      end
      if (is_last !== want.last_result) begin
        errors++;
        $display("%0t: last_result expected %0b actual %0b", $time, want.last_result,
                 is_last);
      end
      if (ovf !== want.overflowed) begin
        errors++;
        $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed, ovf);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  isu_in_if  in_bus ();
  isu_out_if out_bus ();

  insertion_sorter_unit #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  sorted_list_checker sorter_model = new();
  data_t       list_q[$];
  bit          calm;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Transfer monitor: input first, so a list's results are due before they can appear.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        sorter_model.note_value(in_bus.value, in_bus.last_item);
      if (out_bus.valid && out_bus.ready)
        sorter_model.check_result(out_bus.sorted_value, out_bus.last_result,
                                  out_bus.overflowed);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= MaxIdle) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("[insertion_sorter_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic data_t draw_value();
    case ($urandom_range(0, 7))
      0: return data_t'($urandom_range(0, 16)) - 8;
      1: begin
        case ($urandom_range(0, 3))
          0: return MinValue;
          1: return MaxValue;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offers every value of list_q in order; valid stays high across back-to-back items.
  task automatic send_list();
    int unsigned gap;
    for (int i = 0; i < list_q.size(); i++) begin
      gap = draw_wait();
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_bus.valid     <= 1'b1;
      in_bus.value     <= list_q[i];
      in_bus.last_item <= (i == list_q.size() - 1);
      do @(posedge clk_i); while (!in_bus.ready);
    end
  endtask

  // The extra edge lets the monitor note the final input transfer before the check.
  task automatic wait_drained();
    @(posedge clk_i);
    while (sorter_model.due_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned gap, taken;
    bit held_long;
    taken     = 0;
    held_long = 1'b0;
    out_bus.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_long && taken >= 100) begin
        // Hold ready low for a long stretch, so a list being emitted keeps the input stalled.
        held_long = 1'b1;
        gap = LongHold;
      end else begin
        gap = draw_wait();
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned len, shape, list_no;
    in_bus.valid     <= 1'b0;
    in_bus.value     <= '0;
    in_bus.last_item <= 1'b0;
    calm = 1'b0;
    while (!rst_ni) @(posedge clk_i);

    // Directed lists: single extremes, mixed extremes, duplicates, both orders.
    list_q = '{MinValue};
    send_list();
    list_q = '{MaxValue};
    send_list();
    list_q = '{data_t'(0), data_t'(-1), MaxValue, MinValue, data_t'(1)};
    send_list();
    list_q = '{data_t'(5), data_t'(-3), data_t'(5), data_t'(5), data_t'(-3), data_t'(7)};
    send_list();
    list_q = '{data_t'(3), data_t'(2), data_t'(1), data_t'(0), data_t'(-1), data_t'(-2)};
    send_list();
    list_q = '{MinValue, data_t'(-1), data_t'(0), MaxValue};
    send_list();

    list_no = 0;
    while (sorter_model.values < TargetValues) begin
      // The first lists exactly fill the store, drop the last value, and drop many.
      case (list_no)
        0: len = Depth;
        1: len = Depth + 1;
        2: len = Depth + 8;
        default: len = ($urandom_range(0, 5) == 0) ? $urandom_range(Depth - 4, Depth + 8)
                                                    : $urandom_range(1, 12);
      endcase
      shape = $urandom_range(0, 3);
      calm  = ($urandom_range(0, 3) == 0);
      list_q.delete();
      for (int unsigned i = 0; i < len; i++) begin
        if (shape == 3) list_q.push_back(data_t'($urandom_range(0, 3)) - 2);
        else list_q.push_back(draw_value());
      end
      if (shape == 1) list_q.sort();
      else if (shape == 2) list_q.rsort();
      send_list();
      if (list_no == 6) begin
        // Let the block go fully idle before the next list.
        in_bus.valid <= 1'b0;
        wait_drained();
      end
      list_no++;
    end
    in_bus.valid <= 1'b0;
    calm = 1'b0;

    wait_drained();
    repeat (2 * Depth + 20) @(posedge clk_i);
    if (sorter_model.due_results.size() != 0) begin
      sorter_model.errors++;
      $display("%0t: %0d results never arrived", $time, sorter_model.due_results.size());
    end
    $display("Sorted %0d lists from %0d values into %0d results.", sorter_model.lists,
             sorter_model.values, sorter_model.results);
    $display("Lists that overflowed the store: %0d; longest list emitted: %0d.",
             sorter_model.overflow_lists, sorter_model.longest);
    if (sorter_model.errors == 0) begin
      $display("[insertion_sorter_unit] OK");
    end else begin
      $display("[insertion_sorter_unit] ERROR");
    end
    $finish;
  end

endmodule : tb_insertion_sorter_unit

FILE: insertion_sorter_unit.f
sv/isu_pkg.sv
sv/isu_stream_if.sv
sv/isu_cell.sv
sv/insertion_sorter_unit.sv
tb/sv/tb_insertion_sorter_unit.sv
